### src/spgm_pkg.sv
// Shared types, widths and register codes for the stereo pan and gain mixer.
`timescale 1ns / 1ps

package spgm_pkg;

   localparam int CHANNELS   = 8;
   localparam int CHAN_W     = 3;
   localparam int SAMPLE_W   = 16;
   localparam int VOL_W      = 8;
   localparam int GAIN_SHIFT = 8;
   localparam int ACC_W      = 20;
   localparam int SLICE_W    = 10;
   localparam int PAIRS      = 4;
   localparam int PAIR_W     = 2 * SLICE_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = PAIR_W;
   localparam int PROD_W     = SAMPLE_W + VOL_W + 1;

   typedef enum logic [1:0] {
      PAN_CENTER = 2'd0,
      PAN_LEFT   = 2'd1,
      PAN_RIGHT  = 2'd2,
      PAN_OFF    = 2'd3
   } pan_type;

   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_PAIR_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_PAIR_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_PAIR_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_PAIR_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_ENABLE  = 3'd4;

   function automatic logic out_of_16(input logic [ACC_W-1:0] acc);
      logic [ACC_W-SAMPLE_W:0] top;
      top = acc[ACC_W-1:SAMPLE_W-1];
      return !((&top) || (~|top));
   endfunction

endpackage

### src/stereo_pan_gain_mixer.sv
// Top level of the stereo pan and gain mixer.
`timescale 1ns / 1ps

// One request carries one channel sample. It is registered, then scaled by the channel
// volume (one 16 x 8 multiply, floor shift right by 8) and added to the left and/or right
// 20-bit accumulator according to the channel pan code. A request marked last loads a
// left/right result into the output register and clears both accumulators. A request is
// taken every cycle; the only stall is a last request meeting a result that is still
// waiting, so the sustained rate is one request per cycle. Configuration is written
// through the csr_ port.
module stereo_pan_gain_mixer
   import spgm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [CHAN_W-1:0]           req_channel,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        req_last,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SAMPLE_W-1:0]  rsp_left,
   output logic signed [SAMPLE_W-1:0]  rsp_right,
   output logic                        rsp_wrapped,

   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   logic [PAIR_W-1:0]           chan_pair_ff [PAIRS];
   logic                        mix_enable_ff;

   logic                        s1_valid_ff;
   logic [CHAN_W-1:0]           s1_channel_ff;
   logic signed [SAMPLE_W-1:0]  s1_sample_ff;
   logic                        s1_last_ff;

   logic [ACC_W-1:0]            acc_left_ff, acc_left_in;
   logic [ACC_W-1:0]            acc_right_ff, acc_right_in;

   logic                        rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]  rsp_left_ff, rsp_right_ff;
   logic                        rsp_wrapped_ff;

   logic                        out_free;
   logic                        s1_go;
   logic                        chan_ok;
   logic [PAIR_W-1:0]           pair_sel;
   logic [SLICE_W-1:0]          slice;
   logic [VOL_W-1:0]            vol;
   pan_type                     pan;
   logic signed [PROD_W-1:0]    prod;
   logic [SAMPLE_W-1:0]         scaled;
   logic [ACC_W-1:0]            add_val;
   logic                        to_left, to_right;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAIRS; i++) begin
            chan_pair_ff[i] <= '0;
         end
         mix_enable_ff <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHAN_PAIR_0: chan_pair_ff[0] <= csr_wdata;
            CSR_CHAN_PAIR_1: chan_pair_ff[1] <= csr_wdata;
            CSR_CHAN_PAIR_2: chan_pair_ff[2] <= csr_wdata;
            CSR_CHAN_PAIR_3: chan_pair_ff[3] <= csr_wdata;
            CSR_MIX_ENABLE:  mix_enable_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_go     = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_go;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_channel_ff <= req_channel;
         s1_sample_ff  <= req_sample;
         s1_last_ff    <= req_last;
      end
   end

   // gain and pan
   always_comb begin
      chan_ok  = {1'b0, s1_channel_ff} < (CHAN_W + 1)'(CHANNELS);
      pair_sel = chan_pair_ff[s1_channel_ff[CHAN_W-1:1]];
      slice    = s1_channel_ff[0] ? pair_sel[PAIR_W-1:SLICE_W] : pair_sel[SLICE_W-1:0];
      vol      = slice[VOL_W-1:0];
      pan      = pan_type'(slice[SLICE_W-1:VOL_W]);
      prod     = PROD_W'(s1_sample_ff) * PROD_W'($signed({1'b0, vol}));
      scaled   = prod[SAMPLE_W+GAIN_SHIFT-1:GAIN_SHIFT];
      add_val  = {{(ACC_W - SAMPLE_W){scaled[SAMPLE_W-1]}}, scaled};
      to_left  = 1'b0;
      to_right = 1'b0;
      case (pan)
         PAN_CENTER: begin
            to_left  = chan_ok;
            to_right = chan_ok;
         end
         PAN_LEFT:  to_left  = chan_ok;
         PAN_RIGHT: to_right = chan_ok;
         default: ;
      endcase
      acc_left_in  = acc_left_ff  + (to_left  ? add_val : '0);
      acc_right_in = acc_right_ff + (to_right ? add_val : '0);
   end

   // accumulators: clear at end of frame
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_left_ff  <= '0;
         acc_right_ff <= '0;
      end else if (s1_go) begin
         acc_left_ff  <= s1_last_ff ? '0 : acc_left_in;
         acc_right_ff <= s1_last_ff ? '0 : acc_right_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_last_ff) begin
         if (mix_enable_ff) begin
            rsp_left_ff    <= acc_left_in[SAMPLE_W-1:0];
            rsp_right_ff   <= acc_right_in[SAMPLE_W-1:0];
            rsp_wrapped_ff <= out_of_16(acc_left_in) || out_of_16(acc_right_in);
         end else begin
            rsp_left_ff    <= '0;
            rsp_right_ff   <= '0;
            rsp_wrapped_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_left    = rsp_left_ff;
   assign rsp_right   = rsp_right_ff;
   assign rsp_wrapped = rsp_wrapped_ff;

   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_last_ff |=> acc_left_ff == '0 && acc_right_ff == '0)
      else $error("accumulators not cleared after end of frame");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_go && s1_last_ff))
      else $error("result appeared without an end-of-frame request");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a waiting result");

endmodule

### verif/stereo_pan_gain_mixer_tb.sv
// Self-checking testbench for the stereo pan and gain mixer: predicted frames against DUT output.
`timescale 1ns / 1ps

module stereo_pan_gain_mixer_tb
   import spgm_pkg::*;
();

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 10;
   localparam int MAX_REPORTS    = 10;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_REQUESTS = 270;
   localparam int PHASES         = 4;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       wrapped;
   } mix_frame_type;

   class mix_scoreboard;
      logic [PAIR_W-1:0] pair_cfg [PAIRS];
      logic              enabled;
      logic [ACC_W-1:0]  acc_left;
      logic [ACC_W-1:0]  acc_right;
      mix_frame_type     expected_frames [$];
      int                mismatches;
      int                frames_checked;

      function new();
         foreach (pair_cfg[i]) pair_cfg[i] = '0;
         enabled        = 1'b1;
         acc_left       = '0;
         acc_right      = '0;
         mismatches     = 0;
         frames_checked = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx) inside
            CSR_CHAN_PAIR_0, CSR_CHAN_PAIR_1, CSR_CHAN_PAIR_2, CSR_CHAN_PAIR_3: begin
               pair_cfg[idx[1:0]] = data;
            end
            CSR_MIX_ENABLE: begin
               enabled = data[0];
            end
            default: begin
            end
         endcase
      endfunction

      function logic beyond_16(logic [ACC_W-1:0] acc);
         logic signed [ACC_W-1:0] level;
         level = acc;
         return (level < -32768) || (level > 32767);
      endfunction

      function void note_request(logic [CHAN_W-1:0] ch, logic signed [SAMPLE_W-1:0] smp,
                                 logic lst);
         logic [SLICE_W-1:0]        slice;
         pan_type                   pan;
         logic signed [PROD_W-1:0]  prod;
         logic signed [PROD_W-1:0]  scaled;
         logic [ACC_W-1:0]          add;
         mix_frame_type             frame;
         if (ch < CHANNELS) begin
            slice  = SLICE_W'(pair_cfg[ch[CHAN_W-1:1]] >> (ch[0] * SLICE_W));
            pan    = pan_type'(slice[SLICE_W-1:VOL_W]);
            prod   = PROD_W'(smp) * PROD_W'($signed({1'b0, slice[VOL_W-1:0]}));
            scaled = prod >>> GAIN_SHIFT;
            add    = scaled[ACC_W-1:0];
            if (pan == PAN_CENTER || pan == PAN_LEFT) acc_left = acc_left + add;
            if (pan == PAN_CENTER || pan == PAN_RIGHT) acc_right = acc_right + add;
         end
         if (lst) begin
            if (enabled) begin
               frame.left    = acc_left[SAMPLE_W-1:0];
               frame.right   = acc_right[SAMPLE_W-1:0];
               frame.wrapped = beyond_16(acc_left) || beyond_16(acc_right);
            end else begin
               frame = '0;
            end
            expected_frames.push_back(frame);
            acc_left  = '0;
            acc_right = '0;
         end
      endfunction

      function void flag(string what, mix_frame_type want, mix_frame_type got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t mismatch (%s): expected L=%0d R=%0d W=%0b, got L=%0d R=%0d W=%0b",
                     $realtime, what, $signed(want.left), $signed(want.right), want.wrapped,
                     $signed(got.left), $signed(got.right), got.wrapped);
      endfunction

      function void check_frame(mix_frame_type got);
         mix_frame_type want;
         if (expected_frames.size() == 0) begin
            want = '0;
            flag("no frame expected", want, got);
            return;
         end
         want = expected_frames.pop_front();
         frames_checked++;
         if (got.left !== want.left || got.right !== want.right || got.wrapped !== want.wrapped)
            flag("frame contents", want, got);
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [CHAN_W-1:0]           req_channel;
   logic signed [SAMPLE_W-1:0]  req_sample;
   logic                        req_last;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [SAMPLE_W-1:0]  rsp_left;
   logic signed [SAMPLE_W-1:0]  rsp_right;
   logic                        rsp_wrapped;
   logic                        csr_wr_en;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;

   mix_scoreboard sb;
   int            send_idle_pct = 0;
   int            rsp_stall_pct = 0;
   int            requests_sent = 0;
   int            csr_writes    = 0;
   int            quiet_cycles  = 0;

   stereo_pan_gain_mixer DUT (.*);

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   always @(negedge clock) rsp_ready = ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_frame({rsp_left, rsp_right, rsp_wrapped});
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [PAIR_W-1:0] make_pair(pan_type pan_hi, logic [VOL_W-1:0] vol_hi,
                                                    pan_type pan_lo, logic [VOL_W-1:0] vol_lo);
      return {pan_hi, vol_hi, pan_lo, vol_lo};
   endfunction

   function automatic logic [PAIR_W-1:0] pick_pair();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return make_pair(PAN_CENTER, '1, PAN_CENTER, '1);
         default: return PAIR_W'($urandom());
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
         1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
         2: return '1;
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   task automatic send_request(input logic [CHAN_W-1:0] ch,
                               input logic signed [SAMPLE_W-1:0] smp, input logic lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_channel = ch;
      req_sample  = smp;
      req_last    = lst;
      do @(posedge clock); while (!req_ready);
      sb.note_request(ch, smp, lst);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      sb.write_reg(idx, data);
      csr_writes++;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // hold off until every frame is out and the pipeline has emptied
   task automatic wait_for_frames();
      req_valid = 1'b0;
      while (sb.expected_frames.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_random_frame();
      int len;
      len = ($urandom_range(15) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
      for (int n = 1; n <= len; n++)
         send_request(CHAN_W'($urandom()), pick_sample(), n == len);
   endtask

   initial begin
      int phase_start;
      bit paused;
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_channel = '0;
      req_sample  = '0;
      req_last    = 1'b0;
      rsp_ready   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      send_request(3'd0, 16'sh7FFF, 1'b1);
      wait_for_frames();
      write_csr(CSR_CHAN_PAIR_0, make_pair(PAN_LEFT, 8'hFF, PAN_CENTER, 8'hFF));
      write_csr(CSR_CHAN_PAIR_1, make_pair(PAN_OFF, 8'hFF, PAN_RIGHT, 8'hFF));
      write_csr(CSR_CHAN_PAIR_2, make_pair(PAN_LEFT, 8'h80, PAN_CENTER, 8'h01));
      write_csr(CSR_CHAN_PAIR_3, make_pair(PAN_RIGHT, 8'hC8, PAN_CENTER, 8'h00));
      for (int idx = CSR_MIX_ENABLE + 1; idx < 2 ** CSR_IDX_W; idx++)
         write_csr(CSR_IDX_W'(idx), '1);

      send_request(3'd0, 16'sh8000, 1'b1);
      send_request(3'd0, 16'sh7FFF, 1'b1);
      send_request(3'd0, 16'sh0000, 1'b1);
      send_request(3'd1, 16'shFFFF, 1'b1);
      send_request(3'd4, 16'shFFFF, 1'b1);
      send_request(3'd4, 16'sh0001, 1'b1);
      send_request(3'd2, 16'sh8000, 1'b0);
      send_request(3'd3, 16'sh7FFF, 1'b0);
      send_request(3'd5, 16'sh3039, 1'b0);
      send_request(3'd7, 16'shB1E0, 1'b1);
      send_request(3'd6, 16'sh04D2, 1'b1);
      send_request(3'd0, 16'sh7FFF, 1'b0);
      send_request(3'd0, 16'sh7FFF, 1'b1);
      send_request(3'd0, 16'sh8000, 1'b0);
      send_request(3'd0, 16'sh8000, 1'b1);
      send_request(3'd2, 16'sh8000, 1'b0);
      send_request(3'd2, 16'sh8000, 1'b1);
      wait_for_frames();
      write_csr(CSR_MIX_ENABLE, CSR_DATA_W'(1'b0));
      send_request(3'd0, 16'sh7FFF, 1'b0);
      send_request(3'd1, 16'sh0064, 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_frames();
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 82; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 82; end
            default: begin send_idle_pct = 8; rsp_stall_pct = 8; end
         endcase
         for (int k = 0; k < PAIRS; k++)
            write_csr(CSR_IDX_W'(CSR_CHAN_PAIR_0 + k), pick_pair());
         write_csr(CSR_MIX_ENABLE, CSR_DATA_W'($urandom_range(3) != 0));
         phase_start = requests_sent;
         paused      = 1'b0;
         while (requests_sent - phase_start < PHASE_REQUESTS) begin
            if (!paused && requests_sent - phase_start >= PHASE_REQUESTS / 2) begin
               wait_for_frames();
               write_csr(CSR_IDX_W'($urandom_range(2 ** CSR_IDX_W - 1)), pick_pair());
               paused = 1'b1;
            end
            send_random_frame();
         end
      end

      wait_for_frames();
      $display("Covered %0d requests and %0d checked frames over %0d handshake phases, %0d writes",
               requests_sent, sb.frames_checked, PHASES, csr_writes);
      $display("Included volume and pan extremes, wrap both ways, disabled mix, %0d mismatches",
               sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_frames.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
